### hdl/interval_timer_three_counters_macros.svh
// Assertion macros used by the interval timer top level.
`ifndef INTERVAL_TIMER_THREE_COUNTERS_MACROS_SVH
`define INTERVAL_TIMER_THREE_COUNTERS_MACROS_SVH

// Same-cycle implication, checked on clk and muted while rst_n is low.
`define ITC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and muted while rst_n is low.
`define ITC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/itc_pkg.sv
// Shared types, codes and constants of the interval timer.
`timescale 1ns / 1ps
`default_nettype none
package itc_pkg;

  // Number of counters built (1 to 3); the result always carries three levels.
  localparam int NUM_COUNTERS = 3;
  localparam int OUT_LANES    = 3;
  localparam int CNT_W        = 16;
  localparam int BYTE_W       = 8;
  localparam int CMD_W        = 3;
  localparam int IDX_W        = 2;

  typedef logic [IDX_W-1:0]  itc_idx_t;
  typedef logic [CNT_W-1:0]  itc_count_t;
  typedef logic [BYTE_W-1:0] itc_byte_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_CTRL  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_GATE  = 3'd4
  } itc_cmd_e;

  typedef enum logic [1:0] {
    ACC_LATCH = 2'd0,
    ACC_LSB   = 2'd1,
    ACC_MSB   = 2'd2,
    ACC_WORD  = 2'd3
  } itc_access_e;

  typedef enum logic [1:0] {
    MODE_ZERO   = 2'd0,
    MODE_RATE   = 2'd2,
    MODE_SQUARE = 2'd3
  } itc_mode_e;

  // Select value that requests readback, which this timer flags as unsupported.
  localparam itc_idx_t SEL_READBACK = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    itc_idx_t         counter_sel;
    itc_byte_t        data_byte;
    logic             gate_in;
  } itc_item_t;

  // One decoded bus operation, already qualified by the pipeline advance.
  typedef struct packed {
    logic        tick;
    logic        prog;
    logic        latch;
    logic        wr;
    logic        rd;
    logic        gate_wr;
    itc_idx_t    tgt;
    itc_access_e rw;
    itc_mode_e   mode;
    itc_byte_t   data;
    logic        gate;
  } itc_op_t;

  typedef struct packed {
    itc_byte_t            read_byte;
    logic [OUT_LANES-1:0] lvl;
    logic                 unsupported;
  } itc_result_t;

  typedef struct packed {
    logic      ok;
    itc_mode_e mode;
  } itc_mode_dec_t;

  // Mode field of a control word: modes 6 and 7 alias to 2 and 3.
  function automatic itc_mode_dec_t itc_decode_mode(input logic [2:0] mf);
    itc_mode_dec_t d;
    d.ok   = 1'b1;
    d.mode = MODE_ZERO;
    case (mf)
      3'd0:       d.mode = MODE_ZERO;
      3'd2, 3'd6: d.mode = MODE_RATE;
      3'd3, 3'd7: d.mode = MODE_SQUARE;
      default:    d.ok   = 1'b0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

### hdl/itc_if.sv
// Valid/ready channel interfaces for timer commands and results.
`timescale 1ns / 1ps
`default_nettype none
interface itc_in_if import itc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  itc_idx_t         counter_sel;
  itc_byte_t        data_byte;
  logic             gate_in;

  modport source (output valid, cmd, counter_sel, data_byte, gate_in, input ready);
  modport sink   (input valid, cmd, counter_sel, data_byte, gate_in, output ready);
endinterface

interface itc_out_if import itc_pkg::*; ();
  logic      valid;
  logic      ready;
  itc_byte_t read_byte;
  logic      out0;
  logic      out1;
  logic      out2;
  logic      unsupported;

  modport source (output valid, read_byte, out0, out1, out2, unsupported, input ready);
  modport sink   (input valid, read_byte, out0, out1, out2, unsupported, output ready);
endinterface
`default_nettype wire

### hdl/itc_decode.sv
// Command and control-word decoder of the interval timer.
`timescale 1ns / 1ps
`default_nettype none
module itc_decode import itc_pkg::*; (
  input  wire logic      go,
  input  wire itc_item_t item,
  output itc_op_t        op,
  output logic           bad
);

  itc_mode_dec_t md;
  itc_idx_t      ctl_sel;
  itc_access_e   ctl_rw;
  logic          sel_ok;
  logic          ctl_sel_ok;

  assign ctl_sel    = item.data_byte[7:6];
  assign ctl_rw     = itc_access_e'(item.data_byte[5:4]);
  assign md         = itc_decode_mode(item.data_byte[3:1]);
  assign sel_ok     = {1'b0, item.counter_sel} < (IDX_W + 1)'(NUM_COUNTERS);
  assign ctl_sel_ok = {1'b0, ctl_sel} < (IDX_W + 1)'(NUM_COUNTERS);

  always_comb begin
    op      = '0;
    op.tgt  = item.counter_sel;
    op.rw   = ctl_rw;
    op.mode = md.mode;
    op.data = item.data_byte;
    op.gate = item.gate_in;
    bad     = 1'b0;
    case (itc_cmd_e'(item.cmd))
      CMD_TICK: op.tick = go;
      CMD_CTRL: begin
        op.tgt = ctl_sel;
        if (ctl_sel == SEL_READBACK) begin
          bad = 1'b1;
        end else if (ctl_sel_ok) begin
          if (ctl_rw == ACC_LATCH) begin
            op.latch = go;
          end else if (!md.ok || item.data_byte[0]) begin
            // Unimplemented mode or BCD counting: the word is dropped.
            bad = 1'b1;
          end else begin
            op.prog = go;
          end
        end
      end
      CMD_WRITE: op.wr      = go && sel_ok;
      CMD_READ:  op.rd      = go && sel_ok;
      CMD_GATE:  op.gate_wr = go && sel_ok;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hdl/itc_counter.sv
// One 16-bit down counter with its access logic, modes 0, 2 and 3.
`timescale 1ns / 1ps
`default_nettype none
module itc_counter import itc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire itc_idx_t id,
  input  wire itc_op_t  op,
  output itc_byte_t     rd_byte,
  output logic          lvl_nxt
);

  itc_count_t  cnt_r, cnt_nxt;
  itc_count_t  reload_r, reload_nxt;
  itc_count_t  held_r, held_nxt;
  logic        hold_vld_r, hold_vld_nxt;
  logic        toggle_r, toggle_nxt;
  itc_access_e acc_r, acc_nxt;
  itc_mode_e   mode_r, mode_nxt;
  logic        lvl_r;
  logic        run_r, run_nxt;
  logic        pend_r, pend_nxt;
  logic        gate_r, gate_nxt;
  logic        gate_prev_r, gate_prev_nxt;
  logic        hit;

  assign hit = (op.tgt == id);

  always_comb begin
    itc_count_t dec;
    itc_count_t rd_val;
    logic       loaded;
    cnt_nxt       = cnt_r;
    reload_nxt    = reload_r;
    held_nxt      = held_r;
    hold_vld_nxt  = hold_vld_r;
    toggle_nxt    = toggle_r;
    acc_nxt       = acc_r;
    mode_nxt      = mode_r;
    lvl_nxt       = lvl_r;
    run_nxt       = run_r;
    pend_nxt      = pend_r;
    gate_nxt      = gate_r;
    gate_prev_nxt = gate_prev_r;
    rd_byte       = '0;
    loaded        = 1'b0;
    dec           = '0;
    rd_val        = hold_vld_r ? held_r : cnt_r;

    if (op.tick) begin
      if (pend_r) begin
        pend_nxt = 1'b0;
        run_nxt  = 1'b1;
        if (mode_r == MODE_ZERO) begin
          // Mode 0 only loads here and starts counting on the next tick.
          lvl_nxt       = 1'b0;
          cnt_nxt       = reload_r;
          gate_prev_nxt = gate_r;
          loaded        = 1'b1;
        end else if (!run_r) begin
          cnt_nxt = reload_r;
        end
      end
      if (!loaded) begin
        if (!gate_r) begin
          gate_prev_nxt = 1'b0;
          if (mode_r != MODE_ZERO) begin
            lvl_nxt = 1'b1;
          end
        end else if (!run_nxt) begin
          gate_prev_nxt = 1'b1;
        end else begin
          gate_prev_nxt = 1'b1;
          case (mode_r)
            MODE_ZERO: begin
              dec     = cnt_nxt - 1'b1;
              cnt_nxt = dec;
              if (dec == '0) begin
                run_nxt = 1'b0;
                lvl_nxt = 1'b1;
              end
            end
            MODE_RATE: begin
              dec     = cnt_nxt - 1'b1;
              cnt_nxt = dec;
              if (!gate_prev_r || dec == '0) begin
                lvl_nxt = 1'b1;
                cnt_nxt = reload_r;
              end else if (dec == itc_count_t'(1)) begin
                lvl_nxt = 1'b0;
              end
            end
            MODE_SQUARE: begin
              dec     = cnt_nxt - (cnt_nxt[0] ? itc_count_t'(1) : itc_count_t'(2));
              cnt_nxt = dec;
              if (!gate_prev_r) begin
                lvl_nxt = 1'b1;
                cnt_nxt = reload_r;
              end else if (dec == '0) begin
                // Odd reloads lose their low bit on the low half-period.
                lvl_nxt = !lvl_r;
                cnt_nxt = {reload_r[CNT_W-1:1], reload_r[0] & !lvl_r};
              end
            end
            default: ;
          endcase
        end
      end
    end else if (hit && op.latch) begin
      if (!hold_vld_r) begin
        held_nxt     = cnt_r;
        hold_vld_nxt = 1'b1;
      end
    end else if (hit && op.prog) begin
      acc_nxt    = op.rw;
      toggle_nxt = 1'b0;
      mode_nxt   = op.mode;
      pend_nxt   = 1'b0;
      run_nxt    = 1'b0;
      lvl_nxt    = (op.mode != MODE_ZERO);
    end else if (hit && op.wr) begin
      case (acc_r)
        ACC_WORD: begin
          if (!toggle_r) begin
            reload_nxt = {reload_r[CNT_W-1:BYTE_W], op.data};
            if (mode_r == MODE_ZERO) begin
              run_nxt = 1'b0;
            end
          end else begin
            reload_nxt = {op.data, reload_r[BYTE_W-1:0]};
            pend_nxt   = 1'b1;
          end
          toggle_nxt = !toggle_r;
        end
        ACC_MSB: begin
          reload_nxt = {op.data, BYTE_W'(0)};
          pend_nxt   = 1'b1;
        end
        default: begin
          reload_nxt = {BYTE_W'(0), op.data};
          pend_nxt   = 1'b1;
        end
      endcase
    end else if (hit && op.rd) begin
      case (acc_r)
        ACC_WORD: begin
          if (!toggle_r) begin
            rd_byte = rd_val[BYTE_W-1:0];
          end else begin
            rd_byte      = rd_val[CNT_W-1:BYTE_W];
            hold_vld_nxt = 1'b0;
          end
          toggle_nxt = !toggle_r;
        end
        ACC_MSB: begin
          rd_byte      = rd_val[CNT_W-1:BYTE_W];
          hold_vld_nxt = 1'b0;
        end
        default: begin
          rd_byte      = rd_val[BYTE_W-1:0];
          hold_vld_nxt = 1'b0;
        end
      endcase
    end else if (hit && op.gate_wr) begin
      gate_nxt = op.gate;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      reload_r    <= '0;
      held_r      <= '0;
      hold_vld_r  <= 1'b0;
      toggle_r    <= 1'b0;
      acc_r       <= ACC_LSB;
      mode_r      <= MODE_ZERO;
      lvl_r       <= 1'b0;
      run_r       <= 1'b0;
      pend_r      <= 1'b0;
      gate_r      <= 1'b1;
      gate_prev_r <= 1'b1;
    end else begin
      cnt_r       <= cnt_nxt;
      reload_r    <= reload_nxt;
      held_r      <= held_nxt;
      hold_vld_r  <= hold_vld_nxt;
      toggle_r    <= toggle_nxt;
      acc_r       <= acc_nxt;
      mode_r      <= mode_nxt;
      lvl_r       <= lvl_nxt;
      run_r       <= run_nxt;
      pend_r      <= pend_nxt;
      gate_r      <= gate_nxt;
      gate_prev_r <= gate_prev_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/interval_timer_three_counters.sv
// Top level of the three-counter programmable interval timer.
`timescale 1ns / 1ps
`default_nettype none
// The timer takes one bus command per input beat (tick all counters, write a
// control word, write or read a counter byte, or set a gate) and returns one
// result beat per command carrying the byte read, the three output levels
// after the command, and a flag for control words the timer cannot honor
// (readback, modes 1, 4 and 5, BCD). It sustains one beat per clock cycle while
// the result side accepts, and a command passes from the input register to the
// result register. The input register feeds a decoder and the counters, which
// apply the command to their state and hand the result to the output register in
// the same cycle, so back-to-back commands see each other's effects in order. The
// input side can still take a beat while a finished result waits, if the input
// register is empty; a stall at the output holds both registers.
module interval_timer_three_counters import itc_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  itc_in_if.sink   in_beat,
  itc_out_if.source out_beat
);

`include "interval_timer_three_counters_macros.svh"

  itc_item_t   in_r;
  logic        in_v_r, in_v_nxt;
  itc_result_t res_r;
  logic        out_v_r, out_v_nxt;
  logic        adv;
  logic        in_take;
  itc_op_t     op;
  logic        bad;
  itc_byte_t   rd_bytes [NUM_COUNTERS];
  logic [NUM_COUNTERS-1:0] lvls;
  logic [OUT_LANES-1:0]    lane_lvl;
  itc_byte_t   rd_any;

  // The held command moves on when the result register is free or draining.
  assign adv            = in_v_r && (!out_v_r || out_beat.ready);
  assign in_beat.ready  = !in_v_r || adv;
  assign in_take        = in_beat.valid && in_beat.ready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (out_beat.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r.cmd         <= in_beat.cmd;
      in_r.counter_sel <= in_beat.counter_sel;
      in_r.data_byte   <= in_beat.data_byte;
      in_r.gate_in     <= in_beat.gate_in;
    end
  end

  // The decoded operation is only live in the cycle the command advances,
  // so counter state changes exactly once per command.
  itc_decode u_decode (
    .go   (adv),
    .item (in_r),
    .op   (op),
    .bad  (bad)
  );

  for (genvar i = 0; i < NUM_COUNTERS; i++) begin : g_cnt
    itc_counter u_counter (
      .clk     (clk),
      .rst_n   (rst_n),
      .id      (itc_idx_t'(i)),
      .op      (op),
      .rd_byte (rd_bytes[i]),
      .lvl_nxt (lvls[i])
    );
  end

  // Only the addressed counter drives a nonzero read byte.
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      rd_any = rd_any | rd_bytes[i];
    end
  end

  // Lanes for counters that are not built report a low level.
  for (genvar i = 0; i < OUT_LANES; i++) begin : g_lane
    if (i < NUM_COUNTERS) begin : g_on
      assign lane_lvl[i] = lvls[i];
    end else begin : g_off
      assign lane_lvl[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r.read_byte   <= rd_any;
      res_r.lvl         <= lane_lvl;
      res_r.unsupported <= bad;
    end
  end

  assign out_beat.valid       = out_v_r;
  assign out_beat.read_byte   = res_r.read_byte;
  assign out_beat.out0        = res_r.lvl[0];
  assign out_beat.out1        = res_r.lvl[1];
  assign out_beat.out2        = res_r.lvl[2];
  assign out_beat.unsupported = res_r.unsupported;

  // An empty result register must never block the input side.
  `ITC_ASSERT_NOW(a_ready_when_empty, !out_v_r, in_beat.ready,
    "input stalled while the result register is empty")
  // Every command that advances lands in the result register.
  `ITC_ASSERT_NEXT(a_adv_gives_result, adv, out_v_r,
    "advanced command produced no result beat")
  // Only a read command returns a nonzero byte.
  `ITC_ASSERT_NEXT(a_read_byte_zero, adv && (in_r.cmd != CMD_READ),
    out_beat.read_byte == '0, "nonzero read byte for a command other than read")

endmodule
`default_nettype wire

### tb/tb_interval_timer_three_counters.sv
// Self-checking testbench for the three-counter interval timer.
`timescale 1ns / 1ps
// The bench sends timer bus commands as beats on the command channel and checks
// every result beat against a cycle-free predictor of the timer kept inside this
// module. A short directed table runs first. It covers reset values, rejected
// control words, missing counters, undefined commands, all access modes, mode
// aliases, count wrap, latching and gate pauses. Random command sequences follow.
// Most of them program a counter, load a count and then tick, read, latch and
// toggle gates. The rest are malformed sequences and plain noise.
module tb_interval_timer_three_counters;
  import itc_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 9;
  localparam int RANDOM_BEATS   = 1850;
  // A command passes from the input register to the result register, so this
  // much quiet after the last result is enough to catch extras.
  localparam int DRAIN_CYCLES   = 8;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int PRINT_LIMIT    = 40;

  // Mode field values of a control word, bits 3:1.
  localparam logic [2:0] MF_ZERO         = 3'd0;
  localparam logic [2:0] MF_ONE          = 3'd1;
  localparam logic [2:0] MF_RATE         = 3'd2;
  localparam logic [2:0] MF_SQUARE       = 3'd3;
  localparam logic [2:0] MF_FOUR         = 3'd4;
  localparam logic [2:0] MF_FIVE         = 3'd5;
  localparam logic [2:0] MF_RATE_ALIAS   = 3'd6;
  localparam logic [2:0] MF_SQUARE_ALIAS = 3'd7;

  // First of the command codes that the timer does not define.
  localparam logic [CMD_W-1:0] CMD_UNDEFINED = 3'd5;
  // Counter index that is not built when the timer has three counters.
  localparam itc_idx_t SEL_ABSENT = 2'd3;

  // One result beat as the timer should produce it. Level bit j is output j.
  typedef struct packed {
    itc_byte_t            rd;
    logic [OUT_LANES-1:0] lvl;
    logic                 unsup;
  } timer_out_t;

  // One row of the directed table. The row's result is typed in only when
  // typed is set. Otherwise the predictor decides it.
  typedef struct {
    logic [CMD_W-1:0] op;
    itc_idx_t         sel;
    itc_byte_t        data;
    logic             gate;
    bit               typed;
    timer_out_t       want;
  } stim_row_t;

  localparam timer_out_t RESULT_IDLE     = '0;
  localparam timer_out_t RESULT_REJECTED = '{rd: 8'h00, lvl: '0, unsup: 1'b1};

  logic clk = 1'b0;
  logic rst_n;

  itc_in_if  cmd_ch ();
  itc_out_if res_ch ();

  interval_timer_three_counters uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (cmd_ch),
    .out_beat (res_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predicted state of every counter.
  itc_count_t  tmr_count     [NUM_COUNTERS];
  itc_count_t  tmr_reload    [NUM_COUNTERS];
  itc_count_t  tmr_latched   [NUM_COUNTERS];
  logic        tmr_latch_ok  [NUM_COUNTERS];
  logic        tmr_flip      [NUM_COUNTERS];
  itc_access_e tmr_access    [NUM_COUNTERS];
  itc_mode_e   tmr_mode      [NUM_COUNTERS];
  logic        tmr_level     [NUM_COUNTERS];
  logic        tmr_run       [NUM_COUNTERS];
  logic        tmr_pend      [NUM_COUNTERS];
  logic        tmr_gate      [NUM_COUNTERS];
  logic        tmr_gate_seen [NUM_COUNTERS];

  timer_out_t expected_results[$];
  int         mismatch_count = 0;
  int         results_seen   = 0;
  int         useful_beats   = 0;
  int         send_idle_pct  = 12;
  int         recv_stall_pct = 80;

  function automatic itc_byte_t ctl(input itc_idx_t s, input itc_access_e a,
                                    input logic [2:0] mf, input logic bcd);
    return {s, a, mf, bcd};
  endfunction

  function automatic stim_row_t row(input logic [CMD_W-1:0] op, input itc_idx_t s,
                                    input itc_byte_t d, input logic g,
                                    input bit typed, input timer_out_t want);
    stim_row_t r;
    r.op    = op;
    r.sel   = s;
    r.data  = d;
    r.gate  = g;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // Apply one command to the predicted state and return the result beat that
  // the timer should produce after the command.
  function automatic timer_out_t timer_step(input logic [CMD_W-1:0] op,
                                            input itc_idx_t s, input itc_byte_t d,
                                            input logic g);
    timer_out_t r;
    itc_idx_t   ws;
    logic [2:0] mf;
    itc_mode_e  m;
    logic       mode_ok;
    logic       was_running;
    logic       loaded;
    itc_count_t v;
    r = '0;
    case (op)
      CMD_TICK: begin
        for (int k = 0; k < NUM_COUNTERS; k++) begin
          m = tmr_mode[k];
          loaded = 1'b0;
          // A finished count write takes effect on this tick. Modes 2 and 3 load
          // only a stopped counter and go on counting in the same tick. Mode 0
          // loads and then waits one tick.
          if (tmr_pend[k]) begin
            was_running = tmr_run[k];
            tmr_pend[k] = 1'b0;
            tmr_run[k]  = 1'b1;
            if (m == MODE_ZERO) begin
              tmr_level[k]     = 1'b0;
              tmr_count[k]     = tmr_reload[k];
              tmr_gate_seen[k] = tmr_gate[k];
              loaded           = 1'b1;
            end else if (!was_running) begin
              tmr_count[k] = tmr_reload[k];
            end
          end
          if (!loaded) begin
            if (!tmr_gate[k]) begin
              // Gate low pauses counting. Periodic modes also force the output high.
              tmr_gate_seen[k] = 1'b0;
              if (m != MODE_ZERO) tmr_level[k] = 1'b1;
            end else if (!tmr_run[k]) begin
              tmr_gate_seen[k] = 1'b1;
            end else begin
              case (m)
                MODE_ZERO: begin
                  tmr_count[k] = tmr_count[k] - 16'd1;
                  if (tmr_count[k] == '0) begin
                    tmr_run[k]   = 1'b0;
                    tmr_level[k] = 1'b1;
                  end
                end
                MODE_RATE: begin
                  tmr_count[k] = tmr_count[k] - 16'd1;
                  if (!tmr_gate_seen[k]) begin
                    tmr_level[k] = 1'b1;
                    tmr_count[k] = tmr_reload[k];
                  end else if (tmr_count[k] == 16'd1) begin
                    tmr_level[k] = 1'b0;
                  end else if (tmr_count[k] == '0) begin
                    tmr_level[k] = 1'b1;
                    tmr_count[k] = tmr_reload[k];
                  end
                end
                default: begin
                  // Square wave: an odd count steps by one once, then by two.
                  tmr_count[k] = tmr_count[k] - (tmr_count[k][0] ? 16'd1 : 16'd2);
                  if (!tmr_gate_seen[k]) begin
                    tmr_level[k] = 1'b1;
                    tmr_count[k] = tmr_reload[k];
                  end else if (tmr_count[k] == '0) begin
                    tmr_level[k] = ~tmr_level[k];
                    tmr_count[k] = {tmr_reload[k][CNT_W-1:1],
                                    tmr_reload[k][0] & tmr_level[k]};
                  end
                end
              endcase
              tmr_gate_seen[k] = 1'b1;
            end
          end
        end
      end
      CMD_CTRL: begin
        ws = d[7:6];
        mf = d[3:1];
        if (ws == SEL_READBACK) begin
          r.unsup = 1'b1;
        end else if (ws < NUM_COUNTERS) begin
          if (itc_access_e'(d[5:4]) == ACC_LATCH) begin
            // A latch that is already held is kept until it is read out.
            if (!tmr_latch_ok[ws]) begin
              tmr_latched[ws]  = tmr_count[ws];
              tmr_latch_ok[ws] = 1'b1;
            end
          end else begin
            mode_ok = 1'b1;
            m       = MODE_ZERO;
            case (mf)
              MF_ZERO:                    m = MODE_ZERO;
              MF_RATE, MF_RATE_ALIAS:     m = MODE_RATE;
              MF_SQUARE, MF_SQUARE_ALIAS: m = MODE_SQUARE;
              default:                    mode_ok = 1'b0;
            endcase
            if (!mode_ok || d[0]) begin
              r.unsup = 1'b1;
            end else begin
              tmr_access[ws] = itc_access_e'(d[5:4]);
              tmr_flip[ws]   = 1'b0;
              tmr_mode[ws]   = m;
              tmr_pend[ws]   = 1'b0;
              tmr_run[ws]    = 1'b0;
              tmr_level[ws]  = (m != MODE_ZERO);
            end
          end
        end
      end
      CMD_WRITE: begin
        if (s < NUM_COUNTERS) begin
          case (tmr_access[s])
            ACC_WORD: begin
              if (!tmr_flip[s]) begin
                tmr_reload[s][7:0] = d;
                if (tmr_mode[s] == MODE_ZERO) tmr_run[s] = 1'b0;
              end else begin
                tmr_reload[s][15:8] = d;
                tmr_pend[s]         = 1'b1;
              end
              tmr_flip[s] = ~tmr_flip[s];
            end
            ACC_MSB: begin
              tmr_reload[s] = {d, 8'h00};
              tmr_pend[s]   = 1'b1;
            end
            default: begin
              tmr_reload[s] = {8'h00, d};
              tmr_pend[s]   = 1'b1;
            end
          endcase
        end
      end
      CMD_READ: begin
        if (s < NUM_COUNTERS) begin
          v = tmr_latch_ok[s] ? tmr_latched[s] : tmr_count[s];
          case (tmr_access[s])
            ACC_WORD: begin
              // Reads share the byte flip-flop with writes.
              if (!tmr_flip[s]) begin
                r.rd = v[7:0];
              end else begin
                r.rd            = v[15:8];
                tmr_latch_ok[s] = 1'b0;
              end
              tmr_flip[s] = ~tmr_flip[s];
            end
            ACC_MSB: begin
              r.rd            = v[15:8];
              tmr_latch_ok[s] = 1'b0;
            end
            default: begin
              r.rd            = v[7:0];
              tmr_latch_ok[s] = 1'b0;
            end
          endcase
        end
      end
      CMD_GATE: begin
        if (s < NUM_COUNTERS) tmr_gate[s] = g;
      end
      default: begin
      end
    endcase
    for (int j = 0; j < OUT_LANES; j++) begin
      r.lvl[j] = (j < NUM_COUNTERS) ? tmr_level[j] : 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("[%0t] result %0d, %s: got 0x%0h, expected 0x%0h",
               $time, results_seen, what, got, want);
    end
  endtask

  // Offer one command beat, with random idle cycles first, and record the
  // predicted result once the timer takes the beat.
  task automatic send_beat(input logic [CMD_W-1:0] op, input itc_idx_t s,
                           input itc_byte_t d, input logic g);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.cmd         <= op;
    cmd_ch.counter_sel <= s;
    cmd_ch.data_byte   <= d;
    cmd_ch.gate_in     <= g;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    expected_results.push_back(timer_step(op, s, d, g));
    if (op <= CMD_GATE) useful_beats++;
  endtask

  // Hold the command channel quiet until every expected result has come back.
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // The result channel stalls at a rate that the active phase sets.
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    timer_out_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", res_ch.read_byte, 0);
      end else begin
        want = expected_results.pop_front();
        if (res_ch.read_byte !== want.rd)
          report_mismatch("read_byte", res_ch.read_byte, want.rd);
        if (res_ch.out0 !== want.lvl[0]) report_mismatch("out0", res_ch.out0, want.lvl[0]);
        if (res_ch.out1 !== want.lvl[1]) report_mismatch("out1", res_ch.out1, want.lvl[1]);
        if (res_ch.out2 !== want.lvl[2]) report_mismatch("out2", res_ch.out2, want.lvl[2]);
        if (res_ch.unsupported !== want.unsup)
          report_mismatch("unsupported", res_ch.unsupported, want.unsup);
      end
    end
  end

  initial begin
    stim_row_t   directed[$];
    stim_row_t   r;
    int          pick;
    int          phase;
    int          sel_k;
    itc_idx_t    tc;
    itc_access_e ta;
    logic [2:0]  tmf;
    itc_count_t  load_val;

    rst_n              = 1'b0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.cmd         = CMD_TICK;
    cmd_ch.counter_sel = '0;
    cmd_ch.data_byte   = '0;
    cmd_ch.gate_in     = 1'b1;
    res_ch.ready       = 1'b0;

    for (int k = 0; k < NUM_COUNTERS; k++) begin
      tmr_count[k]     = '0;
      tmr_reload[k]    = '0;
      tmr_latched[k]   = '0;
      tmr_latch_ok[k]  = 1'b0;
      tmr_flip[k]      = 1'b0;
      tmr_access[k]    = ACC_LSB;
      tmr_mode[k]      = MODE_ZERO;
      tmr_level[k]     = 1'b0;
      tmr_run[k]       = 1'b0;
      tmr_pend[k]      = 1'b0;
      tmr_gate[k]      = 1'b1;
      tmr_gate_seen[k] = 1'b1;
    end

    // Directed table. The first rows expect reset values or a rejected control
    // word, so their results are typed in here.
    directed.push_back(row(CMD_READ, 2'd0, 8'h00, 1'b1, 1'b1, RESULT_IDLE));
    directed.push_back(row(CMD_CTRL, 2'd0, ctl(SEL_READBACK, ACC_WORD, MF_ZERO, 1'b0),
                           1'b1, 1'b1, RESULT_REJECTED));
    directed.push_back(row(CMD_CTRL, 2'd0, ctl(2'd0, ACC_WORD, MF_ONE, 1'b0),
                           1'b1, 1'b1, RESULT_REJECTED));
    directed.push_back(row(CMD_CTRL, 2'd0, ctl(2'd1, ACC_WORD, MF_FOUR, 1'b0),
                           1'b1, 1'b1, RESULT_REJECTED));
    directed.push_back(row(CMD_CTRL, 2'd0, ctl(2'd2, ACC_WORD, MF_FIVE, 1'b0),
                           1'b1, 1'b1, RESULT_REJECTED));
    directed.push_back(row(CMD_CTRL, 2'd0, ctl(2'd0, ACC_WORD, MF_RATE, 1'b1),
                           1'b1, 1'b1, RESULT_REJECTED));
    directed.push_back(row(CMD_READ, SEL_ABSENT, 8'hFF, 1'b1, 1'b1, RESULT_IDLE));
    directed.push_back(row(CMD_UNDEFINED, 2'd1, 8'hFF, 1'b0, 1'b1, RESULT_IDLE));
    directed.push_back(row(CMD_GATE, SEL_ABSENT, 8'h00, 1'b0, 1'b1, RESULT_IDLE));
    // The remaining rows are checked by the predictor.
    directed.push_back(row(CMD_CTRL, 2'd0, ctl(2'd0, ACC_WORD, MF_RATE, 1'b0),
                           1'b1, 1'b0, RESULT_IDLE));
    directed.push_back(row(CMD_WRITE, 2'd0, 8'h03, 1'b1, 1'b0, RESULT_IDLE));
    directed.push_back(row(CMD_WRITE, 2'd0, 8'h00, 1'b1, 1'b0, RESULT_IDLE));
    directed.push_back(row(CMD_CTRL, 2'd0, ctl(2'd1, ACC_WORD, MF_SQUARE_ALIAS, 1'b0),
                           1'b1, 1'b0, RESULT_IDLE));
    directed.push_back(row(CMD_WRITE, 2'd1, 8'hFF, 1'b1, 1'b0, RESULT_IDLE));
    directed.push_back(row(CMD_WRITE, 2'd1, 8'hFF, 1'b1, 1'b0, RESULT_IDLE));
    // A zero count in mode 0 wraps to the top of the range.
    directed.push_back(row(CMD_CTRL, 2'd0, ctl(2'd2, ACC_LSB, MF_ZERO, 1'b0),
                           1'b1, 1'b0, RESULT_IDLE));
    directed.push_back(row(CMD_WRITE, 2'd2, 8'h00, 1'b1, 1'b0, RESULT_IDLE));
    directed.push_back(row(CMD_TICK, 2'd0, 8'h00, 1'b1, 1'b0, RESULT_IDLE));
    directed.push_back(row(CMD_TICK, 2'd3, 8'hFF, 1'b0, 1'b0, RESULT_IDLE));
    directed.push_back(row(CMD_CTRL, 2'd0, ctl(2'd2, ACC_LATCH, MF_ZERO, 1'b0),
                           1'b1, 1'b0, RESULT_IDLE));
    directed.push_back(row(CMD_TICK, 2'd0, 8'h00, 1'b1, 1'b0, RESULT_IDLE));
    directed.push_back(row(CMD_READ, 2'd2, 8'h00, 1'b1, 1'b0, RESULT_IDLE));
    // Gate low pauses counter zero. Raising it again reloads the count.
    directed.push_back(row(CMD_GATE, 2'd0, 8'h00, 1'b0, 1'b0, RESULT_IDLE));
    directed.push_back(row(CMD_TICK, 2'd0, 8'h00, 1'b1, 1'b0, RESULT_IDLE));
    directed.push_back(row(CMD_GATE, 2'd0, 8'h00, 1'b1, 1'b0, RESULT_IDLE));
    directed.push_back(row(CMD_TICK, 2'd0, 8'h00, 1'b1, 1'b0, RESULT_IDLE));
    directed.push_back(row(CMD_CTRL, 2'd0, ctl(2'd0, ACC_MSB, MF_RATE_ALIAS, 1'b0),
                           1'b1, 1'b0, RESULT_IDLE));
    directed.push_back(row(CMD_WRITE, 2'd0, 8'h01, 1'b1, 1'b0, RESULT_IDLE));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      r = directed[i];
      send_beat(r.op, r.sel, r.data, r.gate);
      // The typed result replaces the prediction just queued. The result cannot
      // arrive before the next edge, so the replacement is safe here.
      if (r.typed) expected_results[expected_results.size() - 1] = r.want;
    end

    useful_beats = 0;
    phase        = 0;
    while (useful_beats < RANDOM_BEATS) begin
      // Three phases: the receiver stalls heavily, then the sender idles
      // heavily, then neither side idles. Each later phase starts with the sender
      // paused until every outstanding result is back.
      if (phase == 0 && useful_beats >= RANDOM_BEATS / 3) begin
        phase          = 1;
        send_idle_pct  = 80;
        recv_stall_pct = 12;
        wait_drained();
      end else if (phase == 1 && useful_beats >= 2 * RANDOM_BEATS / 3) begin
        phase          = 2;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drained();
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        // Well-formed sequence: program a counter, load a count and exercise it.
        tc = itc_idx_t'($urandom_range(NUM_COUNTERS - 1));
        ta = itc_access_e'($urandom_range(3, 1));
        case ($urandom_range(4))
          0:       tmf = MF_ZERO;
          1:       tmf = MF_RATE;
          2:       tmf = MF_SQUARE;
          3:       tmf = MF_RATE_ALIAS;
          default: tmf = MF_SQUARE_ALIAS;
        endcase
        send_beat(CMD_CTRL, itc_idx_t'($urandom), ctl(tc, ta, tmf, 1'b0), 1'($urandom));
        pick = $urandom_range(99);
        if (pick < 80)      load_val = 16'($urandom_range(12, 1));
        else if (pick < 90) load_val = 16'($urandom);
        else if (pick < 95) load_val = 16'h0000;
        else                load_val = 16'hFFFF;
        case (ta)
          ACC_LSB: send_beat(CMD_WRITE, tc, load_val[7:0], 1'($urandom));
          ACC_MSB: send_beat(CMD_WRITE, tc, (pick < 80) ? 8'h01 : load_val[15:8],
                             1'($urandom));
          default: begin
            send_beat(CMD_WRITE, tc, load_val[7:0], 1'($urandom));
            send_beat(CMD_WRITE, tc, load_val[15:8], 1'($urandom));
          end
        endcase
        repeat ($urandom_range(40, 8)) begin
          pick  = $urandom_range(99);
          sel_k = ($urandom_range(19) == 0) ? SEL_ABSENT : $urandom_range(NUM_COUNTERS - 1);
          if (pick < 55) begin
            send_beat(CMD_TICK, itc_idx_t'($urandom), 8'($urandom), 1'($urandom));
          end else if (pick < 70) begin
            send_beat(CMD_READ, itc_idx_t'(sel_k), 8'($urandom), 1'($urandom));
          end else if (pick < 78) begin
            send_beat(CMD_CTRL, itc_idx_t'($urandom),
                      ctl(itc_idx_t'($urandom_range(NUM_COUNTERS - 1)), ACC_LATCH,
                          3'($urandom), 1'($urandom)), 1'($urandom));
          end else if (pick < 88) begin
            send_beat(CMD_GATE, itc_idx_t'(sel_k), 8'($urandom), $urandom_range(99) >= 40);
          end else if (pick < 95) begin
            send_beat(CMD_WRITE, tc,
                      ($urandom_range(99) < 70) ? 8'($urandom_range(12, 1)) : 8'($urandom),
                      1'($urandom));
          end else begin
            send_beat(3'($urandom), itc_idx_t'($urandom), 8'($urandom), 1'($urandom));
          end
        end
        // Most sequences end with every gate raised so that counting resumes.
        if ($urandom_range(99) < 70) begin
          for (int k = 0; k < NUM_COUNTERS; k++) begin
            send_beat(CMD_GATE, itc_idx_t'(k), 8'($urandom), 1'b1);
          end
        end
      end else if (pick < 85) begin
        // Broken sequence: any control word, a stray mix of byte accesses, ticks.
        send_beat(CMD_CTRL, itc_idx_t'($urandom), 8'($urandom), 1'($urandom));
        repeat ($urandom_range(4, 1)) begin
          send_beat($urandom_range(1) ? CMD_WRITE : CMD_READ,
                    itc_idx_t'($urandom_range(NUM_COUNTERS - 1)), 8'($urandom),
                    1'($urandom));
        end
        repeat ($urandom_range(6, 1)) begin
          send_beat(CMD_TICK, itc_idx_t'($urandom), 8'($urandom), 1'($urandom));
        end
      end else begin
        // Noise over every command code, undefined ones included.
        repeat ($urandom_range(6, 1)) begin
          send_beat(3'($urandom), itc_idx_t'($urandom), 8'($urandom), 1'($urandom));
        end
      end
    end

    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("interval_timer_three_counters verification clean");
    end else begin
      $display("interval_timer_three_counters verification failed");
    end
    $finish;
  end

  // Watchdog that stops a run whose results stop coming back.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("interval_timer_three_counters verification failed");
    $finish;
  end

endmodule
